### rtl/snd_pkg.sv
// ----------------------------------------------------------------------------
// snd_pkg
// Shared types and register addresses of the sound unit register file.
// ----------------------------------------------------------------------------
package snd_pkg;

	// bus access codes
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// register addresses
	localparam logic [15:0] ADDR_NR10 = 16'hff10;
	localparam logic [15:0] ADDR_NR11 = 16'hff11;
	localparam logic [15:0] ADDR_NR12 = 16'hff12;
	localparam logic [15:0] ADDR_NR13 = 16'hff13;
	localparam logic [15:0] ADDR_NR14 = 16'hff14;
	localparam logic [15:0] ADDR_NR21 = 16'hff16;
	localparam logic [15:0] ADDR_NR22 = 16'hff17;
	localparam logic [15:0] ADDR_NR23 = 16'hff18;
	localparam logic [15:0] ADDR_NR24 = 16'hff19;
	localparam logic [15:0] ADDR_NR30 = 16'hff1a;
	localparam logic [15:0] ADDR_NR31 = 16'hff1b;
	localparam logic [15:0] ADDR_NR32 = 16'hff1c;
	localparam logic [15:0] ADDR_NR33 = 16'hff1d;
	localparam logic [15:0] ADDR_NR34 = 16'hff1e;
	localparam logic [15:0] ADDR_NR41 = 16'hff20;
	localparam logic [15:0] ADDR_NR42 = 16'hff21;
	localparam logic [15:0] ADDR_NR43 = 16'hff22;
	localparam logic [15:0] ADDR_NR44 = 16'hff23;
	localparam logic [15:0] ADDR_NR50 = 16'hff24;
	localparam logic [15:0] ADDR_NR51 = 16'hff25;
	localparam logic [15:0] ADDR_NR52 = 16'hff26;

	// wave table occupies 0xff30..0xff3f, selected by the upper twelve bits
	localparam logic [11:0] WAVE_PAGE = 12'hff3;

	// one bus access as it moves through the block
	typedef struct packed {
		logic        operation;
		logic [15:0] address;
		logic [7:0]  write_data;
	} access_t;

endpackage

### rtl/snd_regs.sv
// ----------------------------------------------------------------------------
// snd_regs
// Register storage, write unpacking and read packing of the sound unit.
// ----------------------------------------------------------------------------
module snd_regs import snd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  access_t    acc,
	output logic [7:0] rd_data
);

	// channel slots of the shared arrays
	localparam int unsigned CH_SQ1   = 0;
	localparam int unsigned CH_SQ2   = 1;
	localparam int unsigned CH_WAVE  = 2;
	localparam int unsigned CH_NOISE = 3;
	localparam int unsigned ENV_NOISE = 2;

	logic [2:0]  sq1_sweep_period_q;
	logic        sq1_sweep_down_q;
	logic [2:0]  sq1_sweep_step_q;
	logic [1:0]  square_duty_q [2];
	logic [5:0]  square_length_q [2];
	logic [3:0]  envelope_start_volume_q [3];
	logic        envelope_rising_q [3];
	logic [2:0]  envelope_period_q [3];
	logic [10:0] tone_frequency_q [3];
	logic        trigger_flag_q [4];
	logic        length_enable_q [4];
	logic        wave_off_q;
	logic [7:0]  wave_length_q;
	logic [1:0]  wave_level_q;
	logic [7:0]  wave_table_q [16];
	logic [5:0]  noise_length_q;
	logic [3:0]  noise_clock_shift_q;
	logic        noise_narrow_mode_q;
	logic [2:0]  noise_divisor_q;
	logic [7:0]  master_volume_byte_q;
	logic [7:0]  panning_byte_q;
	logic        master_enable_q;
	logic [3:0]  channel_enable_bits_q;

	logic       wave_hit;
	logic [7:0] d;

	assign wave_hit = (acc.address[15:4] == WAVE_PAGE);
	assign d        = acc.write_data;

	// write decode and field unpacking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq1_sweep_period_q <= '0;
			sq1_sweep_down_q   <= 1'b0;
			sq1_sweep_step_q   <= '0;
			for (int i = 0; i < 2; i++) begin
				square_duty_q[i]   <= '0;
				square_length_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				envelope_start_volume_q[i] <= '0;
				envelope_rising_q[i]       <= 1'b0;
				envelope_period_q[i]       <= '0;
				tone_frequency_q[i]        <= '0;
			end
			for (int i = 0; i < 4; i++) begin
				trigger_flag_q[i]  <= 1'b0;
				length_enable_q[i] <= 1'b0;
			end
			wave_off_q    <= 1'b0;
			wave_length_q <= '0;
			wave_level_q  <= '0;
			for (int i = 0; i < 16; i++) begin
				wave_table_q[i] <= '0;
			end
			noise_length_q        <= '0;
			noise_clock_shift_q   <= '0;
			noise_narrow_mode_q   <= 1'b0;
			noise_divisor_q       <= '0;
			master_volume_byte_q  <= '0;
			panning_byte_q        <= '0;
			master_enable_q       <= 1'b0;
			channel_enable_bits_q <= '0;
		end else if (wr_en) begin
			if (wave_hit) begin
				wave_table_q[acc.address[3:0]] <= d;
			end else begin
				unique case (acc.address)
					ADDR_NR10: begin
						sq1_sweep_period_q <= d[6:4];
						sq1_sweep_down_q   <= d[3];
						sq1_sweep_step_q   <= d[2:0];
					end
					ADDR_NR11: begin
						square_duty_q[CH_SQ1]   <= d[7:6];
						square_length_q[CH_SQ1] <= d[5:0];
					end
					ADDR_NR12: begin
						envelope_start_volume_q[CH_SQ1] <= d[7:4];
						envelope_rising_q[CH_SQ1]       <= d[3];
						envelope_period_q[CH_SQ1]       <= d[2:0];
					end
					ADDR_NR13: tone_frequency_q[CH_SQ1][7:0] <= d;
					ADDR_NR14: begin
						trigger_flag_q[CH_SQ1]         <= d[7];
						length_enable_q[CH_SQ1]        <= d[6];
						tone_frequency_q[CH_SQ1][10:8] <= d[2:0];
					end
					ADDR_NR21: begin
						square_duty_q[CH_SQ2]   <= d[7:6];
						square_length_q[CH_SQ2] <= d[5:0];
					end
					ADDR_NR22: begin
						envelope_start_volume_q[CH_SQ2] <= d[7:4];
						envelope_rising_q[CH_SQ2]       <= d[3];
						envelope_period_q[CH_SQ2]       <= d[2:0];
					end
					ADDR_NR23: tone_frequency_q[CH_SQ2][7:0] <= d;
					ADDR_NR24: begin
						trigger_flag_q[CH_SQ2]         <= d[7];
						length_enable_q[CH_SQ2]        <= d[6];
						tone_frequency_q[CH_SQ2][10:8] <= d[2:0];
					end
					ADDR_NR30: wave_off_q    <= d[7];
					ADDR_NR31: wave_length_q <= d;
					ADDR_NR32: wave_level_q  <= d[6:5];
					ADDR_NR33: tone_frequency_q[CH_WAVE][7:0] <= d;
					ADDR_NR34: begin
						trigger_flag_q[CH_WAVE]         <= d[7];
						length_enable_q[CH_WAVE]        <= d[6];
						tone_frequency_q[CH_WAVE][10:8] <= d[2:0];
					end
					ADDR_NR41: noise_length_q <= d[5:0];
					// noise envelope volume sits in the upper nibble like the others
					ADDR_NR42: begin
						envelope_start_volume_q[ENV_NOISE] <= d[7:4];
						envelope_rising_q[ENV_NOISE]       <= d[3];
						envelope_period_q[ENV_NOISE]       <= d[2:0];
					end
					ADDR_NR43: begin
						noise_clock_shift_q <= d[7:4];
						noise_narrow_mode_q <= d[3];
						noise_divisor_q     <= d[2:0];
					end
					// noise control carries no frequency bits
					ADDR_NR44: begin
						trigger_flag_q[CH_NOISE]  <= d[7];
						length_enable_q[CH_NOISE] <= d[6];
					end
					ADDR_NR50: master_volume_byte_q <= d;
					ADDR_NR51: panning_byte_q       <= d;
					ADDR_NR52: begin
						master_enable_q       <= d[7];
						channel_enable_bits_q <= d[3:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// read packing, write-only bits read as zero
	always_comb begin
		rd_data = '0;
		if (wave_hit) begin
			rd_data = wave_table_q[acc.address[3:0]];
		end else begin
			unique case (acc.address)
				ADDR_NR10: rd_data = {1'b0, sq1_sweep_period_q, sq1_sweep_down_q,
					sq1_sweep_step_q};
				ADDR_NR11: rd_data = {square_duty_q[CH_SQ1], 6'd0};
				ADDR_NR12: rd_data = {envelope_start_volume_q[CH_SQ1],
					envelope_rising_q[CH_SQ1], envelope_period_q[CH_SQ1]};
				ADDR_NR14: rd_data = {1'b0, length_enable_q[CH_SQ1], 6'd0};
				ADDR_NR21: rd_data = {square_duty_q[CH_SQ2], 6'd0};
				ADDR_NR22: rd_data = {envelope_start_volume_q[CH_SQ2],
					envelope_rising_q[CH_SQ2], envelope_period_q[CH_SQ2]};
				ADDR_NR24: rd_data = {1'b0, length_enable_q[CH_SQ2], 6'd0};
				ADDR_NR30: rd_data = {wave_off_q, 7'd0};
				ADDR_NR31: rd_data = wave_length_q;
				ADDR_NR32: rd_data = {1'b0, wave_level_q, 5'd0};
				ADDR_NR34: rd_data = {1'b0, length_enable_q[CH_WAVE], 6'd0};
				ADDR_NR41: rd_data = {2'd0, noise_length_q};
				ADDR_NR42: rd_data = {envelope_start_volume_q[ENV_NOISE],
					envelope_rising_q[ENV_NOISE], envelope_period_q[ENV_NOISE]};
				ADDR_NR43: rd_data = {noise_clock_shift_q, noise_narrow_mode_q,
					noise_divisor_q};
				ADDR_NR44: rd_data = {1'b0, length_enable_q[CH_NOISE], 6'd0};
				ADDR_NR50: rd_data = master_volume_byte_q;
				ADDR_NR51: rd_data = panning_byte_q;
				ADDR_NR52: rd_data = {master_enable_q, 7'd0};
				default:   rd_data = '0;
			endcase
		end
	end

endmodule

### rtl/sound_unit_register_file.sv
// ----------------------------------------------------------------------------
// sound_unit_register_file
// Bus-side register file of a four-channel sound unit.
// ----------------------------------------------------------------------------
// One bus access is taken every cycle unless req_stall holds it off. Each
// transfer is registered, then decoded against the register map in the
// following cycle: a write updates the addressed fields at the end of that
// cycle, a read loads the packed value into the response register, and
// writes give no response. Accesses take effect in order, so a read placed
// right behind a write sees the new value. The response register sets the
// rate: while a response is held by rsp_stall, writes keep flowing and a
// pending read waits in the access register.
module sound_unit_register_file import snd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        operation,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [7:0]  read_data
);

	logic       valid_s1;
	access_t    acc_s1;
	logic       rsp_valid_q;
	logic [7:0] read_data_q;
	logic       rsp_free;
	logic       adv_s1;
	logic       is_write_s1;
	logic [7:0] rd_data;

	assign rsp_free    = !rsp_valid_q || !rsp_stall;
	assign is_write_s1 = (acc_s1.operation == OP_WRITE);
	assign adv_s1      = !valid_s1 || is_write_s1 || rsp_free;
	assign req_stall   = !adv_s1;

	// access register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req_valid) begin
			acc_s1 <= '{operation: operation, address: address, write_data: write_data};
		end
	end

	snd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (valid_s1 && is_write_s1),
		.acc     (acc_s1),
		.rd_data (rd_data)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_free) begin
			rsp_valid_q <= valid_s1 && !is_write_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_free && valid_s1 && !is_write_s1) begin
			read_data_q <= rd_data;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign read_data = read_data_q;

endmodule

### rtl/snd_checker.sv
// ----------------------------------------------------------------------------
// snd_checker
// Port-level assertions for the sound unit register file.
// ----------------------------------------------------------------------------
module snd_checker import snd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        operation,
	input logic [15:0] address,
	input logic [7:0]  write_data,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [7:0]  read_data
);

	logic req_xfer;

	assign req_xfer = req_valid && !req_stall;

	// a held response keeps its data
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data))
		else $error("response changed while stalled");

	// a fresh response always comes from an earlier read transfer
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_xfer && (operation == OP_READ), 2))
		else $error("response without a read transfer");

	// unmapped page reads as zero
	a_unmapped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer && (operation == OP_READ) && (address[15:8] != 8'hff)
		##1 (!rsp_valid || !rsp_stall)
		|=> rsp_valid && (read_data == 8'd0))
		else $error("unmapped read returned nonzero data");

	// wave byte written then read back at once returns the written value
	a_wave_readback: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer && (operation == OP_WRITE) && (address[15:4] == WAVE_PAGE)
		##1 (req_xfer && (operation == OP_READ) && (address == $past(address)))
		##1 (!rsp_valid || !rsp_stall)
		|=> rsp_valid && (read_data == $past(write_data, 3)))
		else $error("wave table readback mismatch");

endmodule

bind sound_unit_register_file snd_checker u_snd_checker (.*);

### tb/sv/sound_unit_register_file_checker.sv
// ----------------------------------------------------------------------------
// sound_unit_register_file_checker
// Watches both channels of the sound unit register file, keeps a shadow copy
// of every register field, and compares each returned read byte with the
// value packed from that copy when the read was accepted.
// ----------------------------------------------------------------------------
module sound_unit_register_file_checker import snd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic        operation,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [7:0]  read_data,
	output int          mismatch_count,
	output int          reads_outstanding
);

	// shadow copy of the register fields
	logic [2:0]  sweep_period;
	logic        sweep_negate;
	logic [2:0]  sweep_step;
	logic [1:0]  duty [2];
	logic [5:0]  len_load [2];
	logic [3:0]  env_vol [3];
	logic        env_up [3];
	logic [2:0]  env_pace [3];
	logic [10:0] freq [3];
	logic        trig [4];
	logic        len_en [4];
	logic        wave_dac_off;
	logic [7:0]  wave_len;
	logic [1:0]  wave_vol;
	logic [7:0]  wave_ram [16];
	logic [5:0]  noise_len;
	logic [3:0]  noise_shift;
	logic        noise_width;
	logic [2:0]  noise_div;
	logic [7:0]  vol_ctrl;
	logic [7:0]  pan_ctrl;
	logic        power_on;
	logic [3:0]  chan_on;

	// read bytes still owed by the block, oldest first
	logic [7:0]  read_byte_q [$];
	logic [7:0]  expected_byte;

	initial begin
		mismatch_count    = 0;
		reads_outstanding = 0;
	end

	// envelope register layout, shared by both squares and the noise channel
	function automatic logic [7:0] envelope_byte(input int idx);
		return {env_vol[idx], env_up[idx], env_pace[idx]};
	endfunction

	task automatic set_envelope(input int idx, input logic [7:0] d);
		env_vol[idx]  = d[7:4];
		env_up[idx]   = d[3];
		env_pace[idx] = d[2:0];
	endtask

	// high frequency register: control bits plus the top three frequency bits
	task automatic set_freq_high(input int ch, input logic [7:0] d);
		trig[ch]   = d[7];
		len_en[ch] = d[6];
		freq[ch]   = {d[2:0], freq[ch][7:0]};
	endtask

	// unpack a written byte into the addressed fields
	task automatic apply_write(input logic [15:0] addr, input logic [7:0] d);
		if (addr[15:4] == WAVE_PAGE) begin
			wave_ram[addr[3:0]] = d;
		end else begin
			case (addr)
				ADDR_NR10: begin
					sweep_period = d[6:4];
					sweep_negate = d[3];
					sweep_step   = d[2:0];
				end
				ADDR_NR11: begin
					duty[0]     = d[7:6];
					len_load[0] = d[5:0];
				end
				ADDR_NR12: set_envelope(0, d);
				ADDR_NR13: freq[0][7:0] = d;
				ADDR_NR14: set_freq_high(0, d);
				ADDR_NR21: begin
					duty[1]     = d[7:6];
					len_load[1] = d[5:0];
				end
				ADDR_NR22: set_envelope(1, d);
				ADDR_NR23: freq[1][7:0] = d;
				ADDR_NR24: set_freq_high(1, d);
				ADDR_NR30: wave_dac_off = d[7];
				ADDR_NR31: wave_len = d;
				ADDR_NR32: wave_vol = d[6:5];
				ADDR_NR33: freq[2][7:0] = d;
				ADDR_NR34: set_freq_high(2, d);
				ADDR_NR41: noise_len = d[5:0];
				ADDR_NR42: set_envelope(2, d);
				ADDR_NR43: begin
					noise_shift = d[7:4];
					noise_width = d[3];
					noise_div   = d[2:0];
				end
				// noise control carries no frequency bits
				ADDR_NR44: begin
					trig[3]   = d[7];
					len_en[3] = d[6];
				end
				ADDR_NR50: vol_ctrl = d;
				ADDR_NR51: pan_ctrl = d;
				ADDR_NR52: begin
					power_on = d[7];
					chan_on  = d[3:0];
				end
				default: ;
			endcase
		end
	endtask

	// pack the readable fields; write-only bits and holes read as zero
	function automatic logic [7:0] register_value(input logic [15:0] addr);
		logic [7:0] v;
		v = 8'h00;
		if (addr[15:4] == WAVE_PAGE) begin
			v = wave_ram[addr[3:0]];
		end else begin
			case (addr)
				ADDR_NR10: v = {1'b0, sweep_period, sweep_negate, sweep_step};
				ADDR_NR11: v = {duty[0], 6'h00};
				ADDR_NR12: v = envelope_byte(0);
				ADDR_NR14: v = {1'b0, len_en[0], 6'h00};
				ADDR_NR21: v = {duty[1], 6'h00};
				ADDR_NR22: v = envelope_byte(1);
				ADDR_NR24: v = {1'b0, len_en[1], 6'h00};
				ADDR_NR30: v = {wave_dac_off, 7'h00};
				ADDR_NR31: v = wave_len;
				ADDR_NR32: v = {1'b0, wave_vol, 5'h00};
				ADDR_NR34: v = {1'b0, len_en[2], 6'h00};
				ADDR_NR41: v = {2'b00, noise_len};
				ADDR_NR42: v = envelope_byte(2);
				ADDR_NR43: v = {noise_shift, noise_width, noise_div};
				ADDR_NR44: v = {1'b0, len_en[3], 6'h00};
				ADDR_NR50: v = vol_ctrl;
				ADDR_NR51: v = pan_ctrl;
				ADDR_NR52: v = {power_on, 7'h00};
				default:   v = 8'h00;
			endcase
		end
		return v;
	endfunction

	// track transfers on both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_period = '0;
			sweep_negate = 1'b0;
			sweep_step   = '0;
			foreach (duty[i]) begin
				duty[i]     = '0;
				len_load[i] = '0;
			end
			foreach (env_vol[i]) begin
				env_vol[i]  = '0;
				env_up[i]   = 1'b0;
				env_pace[i] = '0;
				freq[i]     = '0;
			end
			foreach (trig[i]) begin
				trig[i]   = 1'b0;
				len_en[i] = 1'b0;
			end
			wave_dac_off = 1'b0;
			wave_len     = '0;
			wave_vol     = '0;
			foreach (wave_ram[i]) wave_ram[i] = '0;
			noise_len   = '0;
			noise_shift = '0;
			noise_width = 1'b0;
			noise_div   = '0;
			vol_ctrl    = '0;
			pan_ctrl    = '0;
			power_on    = 1'b0;
			chan_on     = '0;
			read_byte_q.delete();
		end else begin
			// a result transfer belongs to an earlier read, so check it first
			if (rsp_valid && !rsp_stall) begin
				if (read_byte_q.size() == 0) begin
					$error("read_data: expected none, actual %h", read_data);
					mismatch_count++;
				end else begin
					expected_byte = read_byte_q.pop_front();
					if (read_data !== expected_byte) begin
						$error("read_data: expected %h, actual %h", expected_byte, read_data);
						mismatch_count++;
					end
				end
			end
			// request transfer updates the shadow copy or queues a read
			if (req_valid && !req_stall) begin
				if (operation == OP_WRITE)
					apply_write(address, write_data);
				else
					read_byte_q.push_back(register_value(address));
			end
		end
		reads_outstanding = read_byte_q.size();
	end

endmodule

### tb/sv/tb_sound_unit_register_file.sv
// ----------------------------------------------------------------------------
// tb_sound_unit_register_file
// Drives bus reads and writes into the sound unit register file: a directed
// pass over field extremes, write-only bits, the noise envelope and unmapped
// addresses, a burst against a held response channel, then random accesses
// with random gaps on both sides. A separate checker does the comparison.
// ----------------------------------------------------------------------------
module tb_sound_unit_register_file;
	import snd_pkg::*;

	localparam int LONG_HOLD    = 120;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 400;
	localparam int DRAIN_CYCLES = 8;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid;
	logic        req_stall;
	logic        operation;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [7:0]  read_data;

	int mismatch_count;
	int reads_outstanding;
	int cycle_count = 0;
	bit quiet        = 1'b0;
	bit hold_rsp_req = 1'b0;

	always #10 clk = ~clk;

	sound_unit_register_file u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.operation  (operation),
		.address    (address),
		.write_data (write_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.read_data  (read_data)
	);

	sound_unit_register_file_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.req_valid         (req_valid),
		.req_stall         (req_stall),
		.operation         (operation),
		.address           (address),
		.write_data        (write_data),
		.rsp_valid         (rsp_valid),
		.rsp_stall         (rsp_stall),
		.read_data         (read_data),
		.mismatch_count    (mismatch_count),
		.reads_outstanding (reads_outstanding)
	);

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// one request transfer after a random gap
	task automatic access(input logic op, input logic [15:0] addr, input logic [7:0] d);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid  <= 1'b1;
		operation  <= op;
		address    <= addr;
		write_data <= d;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// hold the request side until every read has returned
	task automatic drain_reads();
		req_valid <= 1'b0;
		while (reads_outstanding != 0) @(negedge clk);
		@(negedge clk);
	endtask

	// mostly the register block with its holes, then wave table, then anything
	function automatic logic [15:0] pick_address();
		logic [15:0] a;
		int sel;
		a   = 16'($urandom);
		sel = $urandom_range(0, 9);
		if (sel < 6)
			a = 16'(ADDR_NR10 + $urandom_range(0, 31));
		else if (sel < 9)
			a[15:4] = WAVE_PAGE;
		return a;
	endfunction

	// response side: random stalls, one long hold on request
	initial begin : response_side
		int gap;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp_req) begin
				hold_rsp_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
			end
			gap = quiet ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!(rsp_valid && !rsp_stall)) @(posedge clk);
		end
	end

	// request side and verdict
	initial begin : request_side
		logic [15:0] addr;
		req_valid  = 1'b0;
		operation  = OP_READ;
		address    = '0;
		write_data = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: field extremes, write-only bits, noise envelope, holes
		access(OP_WRITE, ADDR_NR10, 8'hff);
		access(OP_READ,  ADDR_NR10, 8'h00);
		access(OP_WRITE, ADDR_NR11, 8'hff);
		access(OP_READ,  ADDR_NR11, 8'hff);
		access(OP_WRITE, ADDR_NR13, 8'hff);
		access(OP_READ,  ADDR_NR13, 8'h00);
		access(OP_WRITE, ADDR_NR14, 8'hff);
		access(OP_READ,  ADDR_NR14, 8'h00);
		access(OP_WRITE, ADDR_NR42, 8'hf5);
		access(OP_READ,  ADDR_NR42, 8'h00);
		access(OP_WRITE, ADDR_NR44, 8'hff);
		access(OP_READ,  ADDR_NR44, 8'h00);
		access(OP_WRITE, ADDR_NR52, 8'hff);
		access(OP_READ,  ADDR_NR52, 8'h00);
		access(OP_WRITE, 16'hff3f,  8'hff);
		access(OP_READ,  16'hff3f,  8'h00);
		access(OP_READ,  16'hff30,  8'hff);
		access(OP_WRITE, 16'hff15,  8'hff);
		access(OP_READ,  16'hff15,  8'h00);
		access(OP_READ,  16'h0000,  8'hff);
		access(OP_WRITE, 16'hffff,  8'hff);
		access(OP_READ,  16'hffff,  8'h00);
		access(OP_WRITE, ADDR_NR10, 8'h00);
		access(OP_READ,  ADDR_NR10, 8'hff);
		drain_reads();

		// back-to-back reads while the response side holds off
		quiet        = 1'b1;
		hold_rsp_req = 1'b1;
		repeat (30) access(OP_READ, pick_address(), 8'h00);
		quiet = 1'b0;
		drain_reads();

		// random accesses, some as write then read of the same register
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			addr = pick_address();
			if ($urandom_range(0, 3) == 0) begin
				access(OP_WRITE, addr, 8'($urandom_range(0, 255)));
				access(OP_READ,  addr, 8'($urandom_range(0, 255)));
			end else begin
				access(1'($urandom_range(0, 1)), addr, 8'($urandom_range(0, 255)));
			end
		end
		quiet = 1'b0;
		drain_reads();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
